[design/rau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  localparam int W  = 16;      // operand width
  localparam int MW = 2 * W;   // width of exact intermediate magnitudes
  localparam int CW = $clog2(MW + 1);

  localparam int IN_TDATA_W  = 4 * W;
  localparam int OUT_TDATA_W = ((2 * W + 1 + 7) / 8) * 8;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_EQ  = 4'd4;
  localparam logic [3:0] OP_NE  = 4'd5;
  localparam logic [3:0] OP_GT  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_RED = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_GCD = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_GCD_DEN, DP_PQ, DP_DIV_GCD, DP_GCD_STEP, DP_ERR,
    DP_MUL_DEN, DP_DIV_LCM, DP_LCM_SET, DP_DIV_SL, DP_SL_SET, DP_DIV_SR,
    DP_SR_SET, DP_XY, DP_COMBINE, DP_DIV_QN, DP_QN_SET, DP_DIV_QD,
    DP_QD_SET, DP_FIN, DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } rau_cmd_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       ga_zero;
    logic       gb_zero;
    logic       div_done;
  } rau_sts_t;

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

endpackage

`default_nettype wire

[design/rau_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rau_div
  import rau_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [MW-1:0] dividend,
  input  wire logic [MW-1:0] divisor,
  output logic      [MW-1:0] quot,
  output logic      [MW-1:0] rem,
  output logic               done
);

  logic [MW-1:0] dsor;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [MW:0]   shifted;
  logic          fit;

  // One quotient bit per cycle, restoring form
  assign shifted = {rem, quot[MW-1]};
  assign fit     = shifted >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      quot <= {quot[MW-2:0], fit};
      rem  <= fit ? MW'(shifted - {1'b0, dsor}) : shifted[MW-1:0];
    end
  end

endmodule

`default_nettype wire

[design/rau_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rau_datapath
  import rau_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rau_cmd_t               cmd,
  output rau_sts_t                    sts,
  input  wire logic [3:0]             in_opcode,
  input  wire logic signed [W-1:0]    in_lhs_num,
  input  wire logic signed [W-1:0]    in_lhs_den,
  input  wire logic signed [W-1:0]    in_rhs_num,
  input  wire logic signed [W-1:0]    in_rhs_den,
  output logic signed [W-1:0]         res_num,
  output logic signed [W-1:0]         res_den,
  output logic                        compare_true,
  output logic [1:0]                  status
);

  logic [3:0]          opcode;
  logic signed [W-1:0] ln, ld, rn, rd;
  logic [MW-1:0]       ga, gb;
  logic                gna, gnb, gk;
  logic [MW-1:0]       prod;
  logic [MW-1:0]       lcm_m, sl_m, sr_m;
  logic                lcm_n, sl_n, sr_n;
  logic signed [MW:0]  x, y;
  logic [MW-1:0]       num_m, den_m, qn, qd;
  logic                num_n, den_n;
  logic signed [W-1:0] rs_num, rs_den;
  logic                rs_cmp;
  logic [1:0]          rs_status;

  logic                div_start, div_done;
  logic [MW-1:0]       div_a, div_b, div_q, div_r;

  logic                g_neg;
  logic [MW-1:0]       xm, ym;
  logic [MW+1:0]       sum;
  logic                sum_neg;
  logic [MW-1:0]       sum_m;
  logic                fn, fd, ok_n, ok_d;
  logic [MW-1:0]       half;

  assign g_neg = gk ? gnb : gna;
  assign half  = MW'(1) << (W - 1);

  assign xm  = MW'(sl_m[W-1:0]) * MW'(mag_w(ln));
  assign ym  = MW'(sr_m[W-1:0]) * MW'(mag_w(rn));
  assign sum = {x[MW], x} + {y[MW], y};
  assign sum_neg = sum[MW+1];
  assign sum_m   = sum_neg ? MW'(-sum) : sum[MW-1:0];

  assign fn   = (num_n != g_neg) && (qn != '0);
  assign fd   = (den_n != g_neg) && (qd != '0);
  assign ok_n = fn ? (qn <= half) : (qn < half);
  assign ok_d = fd ? (qd <= half) : (qd < half);

  always_comb begin
    div_start = 1'b1;
    div_a     = ga;
    div_b     = gb;
    case (cmd.op)
      DP_DIV_GCD: begin div_a = ga;    div_b = gb;               end
      DP_DIV_LCM: begin div_a = prod;  div_b = ga;               end
      DP_DIV_SL:  begin div_a = lcm_m; div_b = MW'(mag_w(ld));   end
      DP_DIV_SR:  begin div_a = lcm_m; div_b = MW'(mag_w(rd));   end
      DP_DIV_QN:  begin div_a = num_m; div_b = ga;               end
      DP_DIV_QD:  begin div_a = den_m; div_b = ga;               end
      default:    div_start = 1'b0;
    endcase
  end

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (div_q),
    .rem      (div_r),
    .done     (div_done)
  );

  assign sts.opcode   = opcode;
  assign sts.ga_zero  = (ga == '0);
  assign sts.gb_zero  = (gb == '0);
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        opcode    <= in_opcode;
        ln        <= in_lhs_num;
        ld        <= in_lhs_den;
        rn        <= in_rhs_num;
        rd        <= in_rhs_den;
        rs_num    <= '0;
        rs_den    <= '0;
        rs_cmp    <= 1'b0;
        rs_status <= ST_OK;
      end
      DP_GCD_DEN: begin
        ga  <= MW'(mag_w(ld));
        gb  <= MW'(mag_w(rd));
        gna <= ld[W-1];
        gnb <= rd[W-1];
        gk  <= 1'b0;
      end
      DP_PQ: begin
        case (opcode)
          OP_MUL: begin
            num_m <= MW'(mag_w(ln)) * MW'(mag_w(rn));
            den_m <= MW'(mag_w(ld)) * MW'(mag_w(rd));
            num_n <= (ln[W-1] ^ rn[W-1]) && ln != '0 && rn != '0;
            den_n <= (ld[W-1] ^ rd[W-1]) && ld != '0 && rd != '0;
          end
          OP_DIV: begin
            num_m <= MW'(mag_w(ln)) * MW'(mag_w(rd));
            den_m <= MW'(mag_w(ld)) * MW'(mag_w(rn));
            num_n <= (ln[W-1] ^ rd[W-1]) && ln != '0 && rd != '0;
            den_n <= (ld[W-1] ^ rn[W-1]) && ld != '0 && rn != '0;
          end
          default: begin
            num_m <= MW'(mag_w(ln));
            den_m <= MW'(mag_w(ld));
            num_n <= ln[W-1];
            den_n <= ld[W-1];
          end
        endcase
      end
      DP_QD_SET: qd <= div_q;
      DP_QN_SET: qn <= div_q;
      DP_GCD_STEP: begin
        ga <= gb;
        gb <= div_r;
        gk <= ~gk;
      end
      DP_ERR: rs_status <= ST_ZERO_GCD;
      DP_MUL_DEN: prod <= MW'(mag_w(ld)) * MW'(mag_w(rd));
      DP_LCM_SET: begin
        lcm_m <= div_q;
        lcm_n <= (ld[W-1] ^ rd[W-1] ^ g_neg) && (div_q != '0);
      end
      DP_SL_SET: begin
        sl_m <= (ld == '0) ? '0 : div_q;
        sl_n <= (ld != '0) && (lcm_n ^ ld[W-1]) && (div_q != '0);
      end
      DP_SR_SET: begin
        sr_m <= (rd == '0) ? '0 : div_q;
        sr_n <= (rd != '0) && (lcm_n ^ rd[W-1]) && (div_q != '0);
      end
      DP_XY: begin
        x <= (sl_n ^ ln[W-1]) ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
        y <= (sr_n ^ rn[W-1] ^ (opcode == OP_SUB)) ?
             -$signed({1'b0, ym}) : $signed({1'b0, ym});
      end
      DP_COMBINE: begin
        case (opcode)
          OP_EQ:   rs_cmp <= (x == y);
          OP_NE:   rs_cmp <= (x != y);
          OP_GT:   rs_cmp <= (x > y);
          OP_LT:   rs_cmp <= (x < y);
          default: rs_cmp <= 1'b0;
        endcase
        num_m <= sum_m;
        num_n <= sum_neg;
        den_m <= lcm_m;
        den_n <= lcm_n;
        ga    <= sum_m;
        gb    <= lcm_m;
        gna   <= sum_neg;
        gnb   <= lcm_n;
        gk    <= 1'b0;
      end
      DP_FIN: begin
        if (ok_n && ok_d) begin
          rs_num <= fn ? W'(-qn) : qn[W-1:0];
          rs_den <= fd ? W'(-qd) : qd[W-1:0];
        end else begin
          rs_status <= ST_OVERFLOW;
        end
      end
      DP_PUBLISH: begin
        res_num      <= rs_num;
        res_den      <= rs_den;
        compare_true <= rs_cmp;
        status       <= rs_status;
      end
      default: ;
    endcase
    // The mul, div and reduce paths seed gcd from the pq step: the products, or the lhs fraction for reduce
    if (cmd.op == DP_PQ) begin
      gk <= 1'b0;
      case (opcode)
        OP_MUL: begin
          ga  <= MW'(mag_w(ln)) * MW'(mag_w(rn));
          gb  <= MW'(mag_w(ld)) * MW'(mag_w(rd));
          gna <= (ln[W-1] ^ rn[W-1]) && ln != '0 && rn != '0;
          gnb <= (ld[W-1] ^ rd[W-1]) && ld != '0 && rd != '0;
        end
        OP_DIV: begin
          ga  <= MW'(mag_w(ln)) * MW'(mag_w(rd));
          gb  <= MW'(mag_w(ld)) * MW'(mag_w(rn));
          gna <= (ln[W-1] ^ rd[W-1]) && ln != '0 && rd != '0;
          gnb <= (ld[W-1] ^ rn[W-1]) && ld != '0 && rn != '0;
        end
        default: begin
          ga  <= MW'(mag_w(ln));
          gb  <= MW'(mag_w(ld));
          gna <= ln[W-1];
          gnb <= ld[W-1];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/rau_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rau_cmd_t      cmd,
  input  wire rau_sts_t sts
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'd1 << 0,
    S_DISP   = 19'd1 << 1,
    S_GCD    = 19'd1 << 2,
    S_GWAIT  = 19'd1 << 3,
    S_GDONE  = 19'd1 << 4,
    S_LDIV   = 19'd1 << 5,
    S_LWAIT  = 19'd1 << 6,
    S_SLDIV  = 19'd1 << 7,
    S_SLWAIT = 19'd1 << 8,
    S_SRDIV  = 19'd1 << 9,
    S_SRWAIT = 19'd1 << 10,
    S_XY     = 19'd1 << 11,
    S_COMB   = 19'd1 << 12,
    S_QNWAIT = 19'd1 << 13,
    S_QDDIV  = 19'd1 << 14,
    S_QDWAIT = 19'd1 << 15,
    S_FIN    = 19'd1 << 16,
    S_DONE   = 19'd1 << 17,
    S_SPARE  = 19'd1 << 18
  } state_t;

  state_t state, state_next;
  logic   phase_den, phase_den_next;
  logic   out_valid_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    phase_den_next = phase_den;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = DP_NONE;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.op     = DP_LOAD;
        state_next = S_DISP;
      end
      S_DISP: begin
        case (sts.opcode) inside
          OP_ADD, OP_SUB, [OP_EQ:OP_LT]: begin
            cmd.op         = DP_GCD_DEN;
            phase_den_next = 1'b1;
            state_next     = S_GCD;
          end
          OP_MUL, OP_DIV, OP_RED: begin
            cmd.op         = DP_PQ;
            phase_den_next = 1'b0;
            state_next     = S_GCD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_GCD: begin
        if (sts.gb_zero) begin
          state_next = S_GDONE;
        end else begin
          cmd.op     = DP_DIV_GCD;
          state_next = S_GWAIT;
        end
      end
      S_GWAIT: if (sts.div_done) begin
        cmd.op     = DP_GCD_STEP;
        state_next = S_GCD;
      end
      S_GDONE: begin
        if (sts.ga_zero) begin
          cmd.op     = DP_ERR;
          state_next = S_DONE;
        end else if (phase_den) begin
          cmd.op     = DP_MUL_DEN;
          state_next = S_LDIV;
        end else begin
          cmd.op     = DP_DIV_QN;
          state_next = S_QNWAIT;
        end
      end
      S_LDIV: begin
        cmd.op     = DP_DIV_LCM;
        state_next = S_LWAIT;
      end
      S_LWAIT: if (sts.div_done) begin
        cmd.op     = DP_LCM_SET;
        state_next = S_SLDIV;
      end
      S_SLDIV: begin
        cmd.op     = DP_DIV_SL;
        state_next = S_SLWAIT;
      end
      S_SLWAIT: if (sts.div_done) begin
        cmd.op     = DP_SL_SET;
        state_next = S_SRDIV;
      end
      S_SRDIV: begin
        cmd.op     = DP_DIV_SR;
        state_next = S_SRWAIT;
      end
      S_SRWAIT: if (sts.div_done) begin
        cmd.op     = DP_SR_SET;
        state_next = S_XY;
      end
      S_XY: begin
        cmd.op     = DP_XY;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.op = DP_COMBINE;
        case (sts.opcode) inside
          [OP_EQ:OP_LT]: state_next = S_DONE;
          default: begin
            phase_den_next = 1'b0;
            state_next     = S_GCD;
          end
        endcase
      end
      S_QNWAIT: if (sts.div_done) begin
        cmd.op     = DP_QN_SET;
        state_next = S_QDDIV;
      end
      S_QDDIV: begin
        cmd.op     = DP_DIV_QD;
        state_next = S_QDWAIT;
      end
      S_QDWAIT: if (sts.div_done) begin
        cmd.op     = DP_QD_SET;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = DP_FIN;
        state_next = S_DONE;
      end
      S_DONE: if (slot_free) begin
        cmd.op         = DP_PUBLISH;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase_den <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase_den <= phase_den_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[design/rational_arith_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Signed-fraction arithmetic unit: add, subtract, multiply, divide, reduce and
// compare two fractions, with every fraction result reduced by a Euclid gcd.
// Input channel s_*: one item holds an opcode (s_tuser) and two fractions
// (s_tdata). Output channel m_*: one item per input item, the reduced
// fraction and compare bit in m_tdata and the status code in m_tuser.
// Items are handled one at a time. Each remainder, the lcm and the two final
// quotients come from one shared restoring divider, one division at a time;
// every Euclid step takes one division.
// A finished item waits in an output register; the next input item is taken
// while it waits, and the following result is held until m_tready frees it.
// Reset (rst, synchronous) returns the controller to idle and drops any
// result not yet taken.
// Unused opcodes give an all-zero result with ok status.

module rational_arith_unit
  import rau_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // lhs_num, lhs_den, rhs_num, rhs_den
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode
  input  wire logic [3:0]             s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // res_num, res_den, compare_true, zero pad
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // status
  output logic [1:0]                  m_tuser
);

  rau_cmd_t            cmd;
  rau_sts_t            sts;
  logic signed [W-1:0] res_num, res_den;
  logic                compare_true;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rau_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (s_tuser),
    .in_lhs_num   (s_tdata[W-1:0]),
    .in_lhs_den   (s_tdata[2*W-1:W]),
    .in_rhs_num   (s_tdata[3*W-1:2*W]),
    .in_rhs_den   (s_tdata[4*W-1:3*W]),
    .res_num      (res_num),
    .res_den      (res_den),
    .compare_true (compare_true),
    .status       (m_tuser)
  );

  assign m_tdata = OUT_TDATA_W'({compare_true, res_den, res_num});

endmodule

`default_nettype wire
